// ===== hdl/mau_pkg.sv =====
// ----------------------------------------------------------------------------
// mau_pkg: shared types and constants for the modular arithmetic unit
// Action codes, widths and the reset modulus.
// ----------------------------------------------------------------------------
`default_nettype none

package mau_pkg;

  localparam int unsigned ResW  = 31;
  localparam int unsigned WideW = 64;
  localparam logic [ResW-1:0] ModReset = 31'd1000000007;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_POW = 3'd4,
    ACT_NEG = 3'd5,
    ACT_RED = 3'd6,
    ACT_NOP = 3'd7
  } action_e;

  // Request to the shared modular reduction unit: value mod m.
  typedef struct packed {
    logic             start;
    logic [WideW-1:0] value;
  } red_req_t;

endpackage

`default_nettype wire

// ===== hdl/modular_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// modular_arithmetic_unit: modular ALU with Fermat inverse
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_stall_o carries action, operands, exponent and
// wide value; output channel out_valid_o/out_stall_i carries the residue and
// the compare flags of the reduced operands. One item is in work at a time.
// Every full reduction (operands, products, wide value) goes through one
// shared bit-serial reduction unit, each request issued from its own state.
// Add, sub, negate and the unused code take 2 reductions; mul and reduce take
// 3. Div runs square-and-multiply over the 31-bit exponent modulus - 2, up to
// 62 reductions. Pow with a 63-bit exponent magnitude takes up to 126
// reductions, plus the inverse when negative.
// The config write cfg_we_i loads the modulus (reset 1000000007); zero acts
// as modulus 1. After reset the block is idle and takes an item at once.
// A result waits in the output register while out_stall_i is high; the next
// item is taken meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_arithmetic_unit #(
  parameter logic [mau_pkg::ResW-1:0] ModResetVal = mau_pkg::ModReset
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [mau_pkg::ResW-1:0]   cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [2:0]                 action_i,
  input  wire logic [mau_pkg::ResW-1:0]   operand_a_i,
  input  wire logic [mau_pkg::ResW-1:0]   operand_b_i,
  input  wire logic signed [63:0]         exponent_i,
  input  wire logic signed [63:0]         wide_value_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [mau_pkg::ResW-1:0]        result_o,
  output logic                            a_less_b_o,
  output logic                            a_equals_b_o
);

  localparam int unsigned W = mau_pkg::ResW;

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_DISP, S_RW, S_INV_SETUP, S_EXP, S_EXP_SQ,
    S_POW_SETUP, S_MULF, S_WAIT, S_DONE
  } state_e;

  // What to do with the reduction result when it returns.
  typedef enum logic [2:0] {
    D_A, D_B, D_R, D_BASE, D_FINAL, D_RW
  } dst_e;

  state_e  state_q;
  dst_e    dst_q;
  state_e  ret_q;
  logic [W-1:0]  mod_q, m_eff;
  logic [W-1:0]  a_q, b_q, r_q, base_q;
  logic [63:0]   e_q, w_q;
  logic [2:0]    act_q;
  logic          wneg_q;
  logic          inv_div_q;
  logic          out_valid_q;
  logic [W-1:0]  res_q;
  logic          lt_q, eq_q;
  logic [W-1:0]  wres_q;
  logic          wlt_q, weq_q;
  mau_pkg::red_req_t req_q;
  logic          red_done;
  logic [W-1:0]  red_rem;
  logic [W:0]    sum;
  logic [W-1:0]  one_m;
  logic [W-1:0]  mul_x;
  logic [63:0]   prod;

  assign m_eff = (mod_q == '0) ? W'(1) : mod_q;
  assign one_m = (m_eff == W'(1)) ? '0 : W'(1);
  assign sum   = {1'b0, a_q} + {1'b0, b_q};

  // single shared multiplier: square in S_EXP_SQ, r * base elsewhere
  assign mul_x = (state_q == S_EXP_SQ) ? base_q : r_q;
  assign prod  = 64'(mul_x) * 64'(base_q);

  mau_reduce u_red (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .mod_i (m_eff),
    .req_i (req_q),
    .done_o(red_done),
    .rem_o (red_rem)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign result_o     = res_q;
  assign a_less_b_o   = lt_q;
  assign a_equals_b_o = eq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mod_q       <= ModResetVal;
      req_q       <= '0;
      dst_q       <= D_A;
      ret_q       <= S_IDLE;
    end else begin
      req_q.start <= 1'b0;
      if (cfg_we_i) mod_q <= cfg_wdata_i;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q       <= action_i;
            a_q         <= operand_a_i;
            b_q         <= operand_b_i;
            e_q         <= exponent_i;
            w_q         <= wide_value_i;
            req_q.start <= 1'b1;
            req_q.value <= 64'(operand_a_i);
            dst_q       <= D_A;
            ret_q       <= S_RB;
            state_q     <= S_WAIT;
          end
        end
        S_RB: begin
          req_q.start <= 1'b1;
          req_q.value <= 64'(b_q);
          dst_q       <= D_B;
          ret_q       <= S_DISP;
          state_q     <= S_WAIT;
        end
        S_DISP: begin
          wlt_q   <= a_q < b_q;
          weq_q   <= a_q == b_q;
          state_q <= S_DONE;
          case (act_q)
            mau_pkg::ACT_ADD: begin
              wres_q <= (sum >= {1'b0, m_eff}) ? W'(sum - {1'b0, m_eff}) : sum[W-1:0];
            end
            mau_pkg::ACT_SUB: begin
              wres_q <= (a_q >= b_q) ? a_q - b_q : W'({1'b0, a_q} + {1'b0, m_eff}
                                                      - {1'b0, b_q});
            end
            mau_pkg::ACT_NEG: wres_q <= (a_q == '0) ? '0 : m_eff - a_q;
            mau_pkg::ACT_MUL: begin
              r_q     <= a_q;
              base_q  <= b_q;
              state_q <= S_MULF;
            end
            mau_pkg::ACT_DIV: begin
              inv_div_q <= 1'b1;
              state_q   <= S_INV_SETUP;
            end
            mau_pkg::ACT_POW: begin
              if (e_q[63]) begin
                inv_div_q <= 1'b0;
                e_q       <= 64'd0 - e_q;
                state_q   <= S_INV_SETUP;
              end else begin
                state_q <= S_POW_SETUP;
              end
            end
            mau_pkg::ACT_RED: begin
              wneg_q      <= w_q[63];
              req_q.start <= 1'b1;
              req_q.value <= w_q[63] ? 64'd0 - w_q : w_q;
              dst_q       <= D_RW;
              ret_q       <= S_DONE;
              state_q     <= S_WAIT;
            end
            default: wres_q <= '0;
          endcase
        end
        S_INV_SETUP: begin
          // base^(m-2); inverse of a residue under modulus 1 stays 0
          w_q     <= 64'(m_eff) - 64'd2;
          base_q  <= inv_div_q ? b_q : a_q;
          r_q     <= one_m;
          state_q <= (m_eff < W'(2)) ? S_POW_SETUP : S_EXP;
          if (m_eff < W'(2)) a_q <= '0;
        end
        S_POW_SETUP: begin
          // plain power: exponent in e_q, base a_q
          if (act_q == mau_pkg::ACT_POW) begin
            base_q <= a_q;
            w_q    <= e_q;
            r_q    <= one_m;
            inv_div_q <= 1'b0;
            act_q  <= mau_pkg::ACT_NOP;
            state_q <= S_EXP;
          end else begin
            // divide after inverse: r = a * inv
            base_q  <= r_q;
            r_q     <= a_q;
            state_q <= S_MULF;
          end
        end
        S_EXP: begin
          if (w_q == 64'd0) begin
            if (inv_div_q) begin
              inv_div_q <= 1'b0;
              act_q     <= mau_pkg::ACT_DIV;
              state_q   <= S_POW_SETUP;
            end else if (act_q == mau_pkg::ACT_POW) begin
              a_q     <= r_q;
              state_q <= S_POW_SETUP;
            end else begin
              wres_q  <= r_q;
              state_q <= S_DONE;
            end
          end else if (w_q[0]) begin
            req_q.start <= 1'b1;
            req_q.value <= prod;
            dst_q       <= D_R;
            ret_q       <= S_EXP_SQ;
            state_q     <= S_WAIT;
          end else begin
            state_q <= S_EXP_SQ;
          end
        end
        S_EXP_SQ: begin
          req_q.start <= 1'b1;
          req_q.value <= prod;
          w_q         <= w_q >> 1;
          dst_q       <= D_BASE;
          ret_q       <= S_EXP;
          state_q     <= S_WAIT;
        end
        S_MULF: begin
          req_q.start <= 1'b1;
          req_q.value <= prod;
          dst_q       <= D_FINAL;
          ret_q       <= S_DONE;
          state_q     <= S_WAIT;
        end
        S_WAIT: begin
          if (red_done) begin
            state_q <= ret_q;
            case (dst_q)
              D_A:    a_q    <= red_rem;
              D_B:    b_q    <= red_rem;
              D_R:    r_q    <= red_rem;
              D_BASE: base_q <= red_rem;
              D_FINAL: wres_q <= red_rem;
              D_RW:   wres_q <= (wneg_q && red_rem != '0) ? m_eff - red_rem : red_rem;
              default: wres_q <= red_rem;
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            res_q       <= wres_q;
            lt_q        <= wlt_q;
            eq_q        <= weq_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> out_valid_q)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q < m_eff || m_eff == W'(1)))
    else $error("result not reduced");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(lt_q && eq_q))
    else $error("flags inconsistent");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_done |-> (state_q == S_WAIT))
    else $error("stray reduction result");

endmodule

`default_nettype wire

// ===== hdl/mau_reduce.sv =====
// ----------------------------------------------------------------------------
// mau_reduce: bit-serial modular reduction
// Reduces a 64-bit unsigned value modulo m, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mau_reduce (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [mau_pkg::ResW-1:0]        mod_i,
  input  wire mau_pkg::red_req_t               req_i,
  output logic                                 done_o,
  output logic [mau_pkg::ResW-1:0]             rem_o
);

  localparam int unsigned CntW = $clog2(mau_pkg::WideW);

  logic [mau_pkg::WideW-1:0] val_q, val_d;
  logic [mau_pkg::ResW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [mau_pkg::ResW:0]    shifted;

  assign shifted = {rem_q, val_q[mau_pkg::WideW-1]};

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      val_d  = req_i.value;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[mau_pkg::WideW-2:0], 1'b0};
      if (shifted >= {1'b0, mod_i}) begin
        rem_d = mau_pkg::ResW'(shifted - {1'b0, mod_i});
      end else begin
        rem_d = shifted[mau_pkg::ResW-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(mau_pkg::WideW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire
